>>> src/salb_pkg.sv
// shared types and constants of the suffix array link builder
`timescale 1ns / 1ps
package salb_pkg;
  localparam int AddrW = 15;
  localparam int WinSize = 32768;
  localparam int CntW = 16;
  localparam int DistCap = 255;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RK_CLR,
    ST_RK_SET,
    ST_RK_SET2,
    ST_LCP_RANK,
    ST_LCP_RANK2,
    ST_LCP_SUF,
    ST_LCP_SUF2,
    ST_LCP_CMP,
    ST_LCP_CMP2,
    ST_NX_INIT,
    ST_NX_RD,
    ST_NX_RD2,
    ST_NX_WALK,
    ST_NX_WALK2,
    ST_PV_INIT,
    ST_PV_RD,
    ST_PV_RD2,
    ST_PV_WALK,
    ST_PV_WALK2,
    ST_QUERY,
    ST_QUERY2,
    ST_OUT
  } state_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;
  localparam logic [0:0] REG_MIN_LEN = 1'b0;
  localparam logic [0:0] REG_MAX_LEN = 1'b1;
endpackage

>>> src/salb_if.sv
// valid/ready channel interfaces of the link builder
`timescale 1ns / 1ps
interface salb_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  text_byte;
  logic [14:0] suffix_position;
  logic        last_item;
  logic [14:0] query_index;
  modport source (output valid, command, text_byte, suffix_position, last_item, query_index,
                  input ready);
  modport sink (input valid, command, text_byte, suffix_position, last_item, query_index,
                output ready);
endinterface

interface salb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  prev_distance;
  logic [9:0]  prev_match_length;
  logic [7:0]  next_distance;
  logic [9:0]  next_match_length;
  logic [14:0] position_rank;
  modport source (output valid, prev_distance, prev_match_length, next_distance,
                  next_match_length, position_rank, input ready);
  modport sink (input valid, prev_distance, prev_match_length, next_distance,
                next_match_length, position_rank, output ready);
endinterface

>>> src/suffix_array_link_builder.sv
// top level: window store, lcp and link build sequencer, read port
`timescale 1ns / 1ps
// usage
//   in: load transactions (command 0) write one text byte and one suffix array
//     entry each, one per cycle while no read result is held; the transaction
//     with last_item set starts the build, during which in.ready is low
//   build: rank memory cleared then filled with the inverse, a kasai lcp pass
//     comparing matched bytes, then the next and prev link passes walking
//     chains; every step is one read of a synchronous memory
//   in: read transactions (command 1) return one out transaction via states
//     query, query2, out; the next is taken once that result is taken
//   out: result is held in an output register while out.ready is low
//   reset: counters and state cleared, registers back to min 2 / max 257,
//     in.ready low while rst_n is low;
//     memories hold garbage until written, no clearing pass
//   cfg: writes taken at any time and used at once, also by a build in progress
module suffix_array_link_builder (
  input  logic clk,
  input  logic rst_n,
  salb_in_if.sink in,
  salb_out_if.source out,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  import salb_pkg::*;

  // memories
  logic [7:0]  text_mem  [WinSize];
  logic [14:0] suf_mem   [WinSize];
  logic [14:0] rank_mem  [WinSize];
  logic [16:0] pp_mem    [WinSize]; // lcp, then prev rank with no-link flag in msb
  logic [16:0] nr_mem    [WinSize]; // next rank with no-link flag
  logic [35:0] link_mem  [WinSize]; // pdist, plen, ndist, nlen

  state_t state_r, state_nxt;
  cnt_t load_cnt_r, win_len_r, n_r;
  logic [9:0] min_len_r, max_len_r;
  cnt_t i_r;          // loop index
  cnt_t t_r;          // chain pointer
  logic t_none_r;
  cnt_t h_r, lim_r, j_r;
  logic [16:0] l_r;   // running min length
  logic [14:0] sr_r;  // suffix of current rank
  logic [14:0] q_r;
  logic out_valid_r;
  logic [7:0] txt_a_r, txt_b_r;
  logic [14:0] suf_rd_r, rank_rd_r;
  logic [16:0] pp_rd_r, nr_rd_r;
  logic [35:0] link_rd_r;

  // memory port controls
  logic        txt_re; addr_t txt_ra, txt_rb;
  logic        suf_re; addr_t suf_ra;
  logic        rank_re, rank_we; addr_t rank_ra, rank_wa; logic [14:0] rank_wd;
  logic        pp_re, pp_we; addr_t pp_ra, pp_wa; logic [16:0] pp_wd;
  logic        nr_re, nr_we; addr_t nr_ra, nr_wa; logic [16:0] nr_wd;
  logic        lk_re, lk_we; addr_t lk_ra, lk_wa; logic [35:0] lk_wd;
  logic        lk_wnext; // write next half only (else prev half)

  logic in_acc;
  assign in.ready = rst_n && (state_r == ST_IDLE) && !out_valid_r;
  assign in_acc = in.valid && in.ready;

  function automatic logic [9:0] clamp_len(input logic [16:0] l, input logic [9:0] mn,
                                            input logic [9:0] mx);
    if (l < {7'd0, mn}) return 10'd0;
    if (l > {7'd0, mx}) return mx;
    return l[9:0];
  endfunction

  function automatic logic [7:0] cap_dist(input cnt_t d);
    if (d > cnt_t'(DistCap)) return 8'(DistCap);
    return d[7:0];
  endfunction

  always_ff @(posedge clk) begin
    if (txt_re) begin
      txt_a_r <= text_mem[txt_ra];
      txt_b_r <= text_mem[txt_rb];
    end
    if (suf_re) suf_rd_r <= suf_mem[suf_ra];
    if (rank_re) rank_rd_r <= rank_mem[rank_ra];
    if (rank_we) rank_mem[rank_wa] <= rank_wd;
    if (pp_re) pp_rd_r <= pp_mem[pp_ra];
    if (pp_we) pp_mem[pp_wa] <= pp_wd;
    if (nr_re) nr_rd_r <= nr_mem[nr_ra];
    if (nr_we) nr_mem[nr_wa] <= nr_wd;
    if (lk_re) link_rd_r <= link_mem[lk_ra];
    if (lk_we) begin
      if (lk_wnext) link_mem[lk_wa][17:0] <= lk_wd[17:0];
      else link_mem[lk_wa][35:18] <= lk_wd[35:18];
    end
    if (in_acc && in.command == CMD_LOAD && load_cnt_r < cnt_t'(WinSize)) begin
      text_mem[load_cnt_r[AddrW-1:0]] <= in.text_byte;
      suf_mem[load_cnt_r[AddrW-1:0]] <= in.suffix_position;
    end
  end

  // build datapath registers
  cnt_t i_nxt, t_nxt, h_nxt, lim_nxt, j_nxt, load_cnt_nxt, win_len_nxt, n_nxt;
  logic t_none_nxt, out_valid_nxt;
  logic [16:0] l_nxt;
  logic [14:0] sr_nxt, q_nxt;
  cnt_t ii, jj;
  logic [9:0] plen, nlen;

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r; t_nxt = t_r; t_none_nxt = t_none_r; h_nxt = h_r; lim_nxt = lim_r;
    j_nxt = j_r; l_nxt = l_r; sr_nxt = sr_r; q_nxt = q_r;
    load_cnt_nxt = load_cnt_r; win_len_nxt = win_len_r; n_nxt = n_r;
    out_valid_nxt = out_valid_r && !out.ready;
    txt_re = 1'b0; txt_ra = '0; txt_rb = '0;
    suf_re = 1'b0; suf_ra = '0;
    rank_re = 1'b0; rank_we = 1'b0; rank_ra = '0; rank_wa = '0; rank_wd = '0;
    pp_re = 1'b0; pp_we = 1'b0; pp_ra = '0; pp_wa = '0; pp_wd = '0;
    nr_re = 1'b0; nr_we = 1'b0; nr_ra = '0; nr_wa = '0; nr_wd = '0;
    lk_re = 1'b0; lk_we = 1'b0; lk_ra = '0; lk_wa = '0; lk_wd = '0; lk_wnext = 1'b0;
    ii = h_r + i_r; jj = h_r + j_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in.command == CMD_READ) begin
            q_nxt = in.query_index;
            state_nxt = ST_QUERY;
          end else begin
            load_cnt_nxt = (load_cnt_r < cnt_t'(WinSize)) ? load_cnt_r + 1'b1 : load_cnt_r;
            if (in.last_item && load_cnt_nxt != '0) begin
              n_nxt = load_cnt_nxt;
              win_len_nxt = load_cnt_nxt;
              load_cnt_nxt = '0;
              i_nxt = '0;
              state_nxt = ST_RK_CLR;
            end
          end
        end
      end
      // inverse suffix array
      ST_RK_CLR: begin
        rank_we = 1'b1; rank_wa = i_r[AddrW-1:0]; rank_wd = '0;
        i_nxt = i_r + 1'b1;
        if (i_nxt == n_r) begin i_nxt = '0; state_nxt = ST_RK_SET; end
      end
      ST_RK_SET: begin
        suf_re = 1'b1; suf_ra = i_r[AddrW-1:0];
        state_nxt = ST_RK_SET2;
      end
      ST_RK_SET2: begin
        if ({1'b0, suf_rd_r} < n_r) begin
          rank_we = 1'b1; rank_wa = suf_rd_r; rank_wd = i_r[AddrW-1:0];
        end
        i_nxt = i_r + 1'b1;
        state_nxt = ST_RK_SET;
        if (i_nxt == n_r) begin
          i_nxt = '0; h_nxt = '0; state_nxt = ST_LCP_RANK;
          pp_we = 1'b1; pp_wa = '0; pp_wd = '0;
        end
      end
      // kasai lcp
      ST_LCP_RANK: begin
        rank_re = 1'b1; rank_ra = i_r[AddrW-1:0];
        state_nxt = ST_LCP_RANK2;
      end
      ST_LCP_RANK2: begin
        if (rank_rd_r == '0) begin
          i_nxt = i_r + 1'b1;
          state_nxt = (i_nxt == n_r) ? ST_NX_INIT : ST_LCP_RANK;
        end else begin
          suf_re = 1'b1; suf_ra = rank_rd_r - 1'b1;
          state_nxt = ST_LCP_SUF;
        end
      end
      ST_LCP_SUF: state_nxt = ST_LCP_SUF2;
      ST_LCP_SUF2: begin
        j_nxt = {1'b0, suf_rd_r};
        if (j_nxt < n_r) lim_nxt = (i_r > j_nxt) ? n_r - i_r : n_r - j_nxt;
        else lim_nxt = '0;
        if (h_r > lim_nxt) h_nxt = lim_nxt;
        state_nxt = ST_LCP_CMP;
      end
      ST_LCP_CMP: begin
        if (h_r < lim_r) begin
          txt_re = 1'b1; txt_ra = ii[AddrW-1:0]; txt_rb = jj[AddrW-1:0];
          state_nxt = ST_LCP_CMP2;
        end else begin
          pp_we = 1'b1; pp_wa = rank_rd_r; pp_wd = {1'b0, h_r};
          if (h_r != '0) h_nxt = h_r - 1'b1;
          i_nxt = i_r + 1'b1;
          state_nxt = (i_nxt == n_r) ? ST_NX_INIT : ST_LCP_RANK;
        end
      end
      ST_LCP_CMP2: begin
        if (txt_a_r == txt_b_r) begin
          h_nxt = h_r + 1'b1;
          state_nxt = ST_LCP_CMP;
        end else begin
          pp_we = 1'b1; pp_wa = rank_rd_r; pp_wd = {1'b0, h_r};
          if (h_r != '0) h_nxt = h_r - 1'b1;
          i_nxt = i_r + 1'b1;
          state_nxt = (i_nxt == n_r) ? ST_NX_INIT : ST_LCP_RANK;
        end
      end
      // next links, rank i_r = k-1 walking down
      ST_NX_INIT: begin
        nr_we = 1'b1; nr_wa = 15'(n_r - 1'b1); nr_wd = 17'h10000;
        lk_we = 1'b1; lk_wnext = 1'b1; lk_wa = 15'(n_r - 1'b1); lk_wd = '0;
        i_nxt = n_r - 1'b1;
        state_nxt = (i_nxt == '0) ? ST_PV_INIT : ST_NX_RD;
      end
      ST_NX_RD: begin
        // read suffix of r = i-1, lcp of t = i
        suf_re = 1'b1; suf_ra = 15'(i_r - 1'b1);
        pp_re = 1'b1; pp_ra = i_r[AddrW-1:0];
        t_nxt = i_r; t_none_nxt = 1'b0;
        state_nxt = ST_NX_RD2;
      end
      ST_NX_RD2: begin
        sr_nxt = suf_rd_r; l_nxt = pp_rd_r;
        suf_re = 1'b1; suf_ra = t_r[AddrW-1:0];
        nr_re = 1'b1; nr_ra = t_r[AddrW-1:0];
        lk_re = 1'b1; lk_ra = t_r[AddrW-1:0];
        state_nxt = ST_NX_WALK;
      end
      ST_NX_WALK: begin
        if (!t_none_r && suf_rd_r > sr_r) begin
          if ({7'd0, link_rd_r[9:0]} < l_r) l_nxt = {7'd0, link_rd_r[9:0]};
          t_nxt = nr_rd_r[15:0]; t_none_nxt = nr_rd_r[16];
          state_nxt = ST_NX_WALK2;
        end else begin
          nr_we = 1'b1; nr_wa = 15'(i_r - 1'b1); nr_wd = {t_none_r, t_r};
          lk_we = 1'b1; lk_wnext = 1'b1; lk_wa = 15'(i_r - 1'b1);
          lk_wd[17:0] = {(t_none_r ? 8'd0 : cap_dist(t_r - i_r + 1'b1)),
                         clamp_len(l_r, min_len_r, max_len_r)};
          i_nxt = i_r - 1'b1;
          state_nxt = (i_nxt == '0) ? ST_PV_INIT : ST_NX_RD;
        end
      end
      ST_NX_WALK2: begin
        suf_re = 1'b1; suf_ra = t_r[AddrW-1:0];
        nr_re = 1'b1; nr_ra = t_r[AddrW-1:0];
        lk_re = 1'b1; lk_ra = t_r[AddrW-1:0];
        state_nxt = ST_NX_WALK;
      end
      // prev links
      ST_PV_INIT: begin
        pp_we = 1'b1; pp_wa = '0; pp_wd = 17'h10000;
        lk_we = 1'b1; lk_wa = '0; lk_wd = '0;
        i_nxt = 16'd1;
        state_nxt = (i_nxt == n_r) ? ST_IDLE : ST_PV_RD;
      end
      ST_PV_RD: begin
        suf_re = 1'b1; suf_ra = i_r[AddrW-1:0];
        pp_re = 1'b1; pp_ra = i_r[AddrW-1:0];
        t_nxt = i_r - 1'b1; t_none_nxt = 1'b0;
        state_nxt = ST_PV_RD2;
      end
      ST_PV_RD2: begin
        sr_nxt = suf_rd_r; l_nxt = pp_rd_r;
        suf_re = 1'b1; suf_ra = t_r[AddrW-1:0];
        pp_re = 1'b1; pp_ra = t_r[AddrW-1:0];
        lk_re = 1'b1; lk_ra = t_r[AddrW-1:0];
        state_nxt = ST_PV_WALK;
      end
      ST_PV_WALK: begin
        if (!t_none_r && suf_rd_r > sr_r) begin
          if ({7'd0, link_rd_r[27:18]} < l_r) l_nxt = {7'd0, link_rd_r[27:18]};
          t_nxt = pp_rd_r[15:0]; t_none_nxt = pp_rd_r[16];
          state_nxt = ST_PV_WALK2;
        end else begin
          pp_we = 1'b1; pp_wa = i_r[AddrW-1:0]; pp_wd = {t_none_r, t_r};
          lk_we = 1'b1; lk_wa = i_r[AddrW-1:0];
          lk_wd[35:18] = {(t_none_r ? 8'd0 : cap_dist(i_r - t_r)),
                          clamp_len(l_r, min_len_r, max_len_r)};
          i_nxt = i_r + 1'b1;
          state_nxt = (i_nxt == n_r) ? ST_IDLE : ST_PV_RD;
        end
      end
      ST_PV_WALK2: begin
        suf_re = 1'b1; suf_ra = t_r[AddrW-1:0];
        pp_re = 1'b1; pp_ra = t_r[AddrW-1:0];
        lk_re = 1'b1; lk_ra = t_r[AddrW-1:0];
        state_nxt = ST_PV_WALK;
      end
      // read command
      ST_QUERY: begin
        lk_re = 1'b1; lk_ra = q_r;
        rank_re = 1'b1; rank_ra = q_r;
        state_nxt = ST_QUERY2;
      end
      ST_QUERY2: state_nxt = ST_OUT;
      ST_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result register
  logic [7:0] pd_r, nd_r;
  logic [9:0] pl_r, nl_r;
  logic [14:0] pr_r;
  logic q_in;
  assign plen = link_rd_r[27:18];
  assign nlen = link_rd_r[9:0];
  assign q_in = ({1'b0, q_r} < win_len_r);
  always_ff @(posedge clk) begin
    if (state_r == ST_OUT) begin
      pd_r <= q_in ? link_rd_r[35:28] : 8'd0;
      pl_r <= q_in ? plen : 10'd0;
      nd_r <= q_in ? link_rd_r[17:10] : 8'd0;
      nl_r <= q_in ? nlen : 10'd0;
      pr_r <= q_in ? rank_rd_r : 15'd0;
    end
  end
  assign out.valid = out_valid_r;
  assign out.prev_distance = pd_r;
  assign out.prev_match_length = pl_r;
  assign out.next_distance = nd_r;
  assign out.next_match_length = nl_r;
  assign out.position_rank = pr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      load_cnt_r <= '0;
      win_len_r <= '0;
      n_r <= '0;
      out_valid_r <= 1'b0;
      min_len_r <= 10'd2;
      max_len_r <= 10'd257;
    end else begin
      state_r <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      win_len_r <= win_len_nxt;
      n_r <= n_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == REG_MIN_LEN) min_len_r <= cfg_data;
      if (cfg_we && cfg_index == REG_MAX_LEN) max_len_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt; t_r <= t_nxt; t_none_r <= t_none_nxt; h_r <= h_nxt;
    lim_r <= lim_nxt; j_r <= j_nxt; l_r <= l_nxt; sr_r <= sr_nxt; q_r <= q_nxt;
  end

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in.ready) else $error("ready while building");
  a_out_after_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT) else $error("stray result");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out.ready) |=> out_valid_r && $stable(pd_r) && $stable(pr_r))
    else $error("result dropped");
  a_lcp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LCP_CMP) |-> h_r <= lim_r) else $error("lcp past bound");
endmodule
